// ===== sv/chash_pkg.sv =====
// Shared types and codes for the chained hash table.
`default_nettype none

package chash_pkg;

    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_INSERT = 1'b1;

    localparam logic [1:0] STATUS_HIT  = 2'd0;
    localparam logic [1:0] STATUS_NEW  = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    typedef struct packed {
        logic       clear_step;
        logic       load_req;
        logic       mod_step;
        logic       head_rd;
        logic       node_rd_head;
        logic       node_rd_link;
        logic       write_value;
        logic       ins_link;
        logic       ins_node;
        logic       res_load;
        logic       res_hit_value;
        logic [1:0] res_status;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic mod_done;
        logic head_valid;
        logic node_match;
        logic link_valid;
        logic have_last;
        logic full;
        logic func;
    } sts_t;

endpackage

`default_nettype wire

// ===== sv/chained_hash_table.sv =====
// Top level of the chained hash table: controller plus datapath.
`default_nettype none

// Key-value table with separate chaining over a pool of NODES nodes and
// BUCKETS chains. After reset the bucket heads are cleared one per cycle,
// so no request is taken until every head is cleared. Requests are
// handled one at a time, walking the chain with one node memory read
// per cycle; an insert that adds a node writes it in a further state,
// after linking it behind an existing tail if the chain has one. When
// BUCKETS is not a power of two the bucket is the remainder of the
// hash found by a reciprocal multiplication, in registered steps for
// the products, the quotient and the remainder. A result waits in the
// output register while the next request is already taken; the next
// result is held back until that register is free.
module chained_hash_table #(
    parameter int BUCKETS = 16,
    parameter int NODES   = 256
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire         func,
    input  wire  [31:0] key,
    input  wire  [31:0] hash_in,
    input  wire  [31:0] value_in,
    output logic        out_valid,
    input  wire         out_ready,
    output logic [1:0]  status,
    output logic [31:0] value_out
);
    import chash_pkg::*;

    cmd_t cmd;
    sts_t sts;

    chash_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    chash_dp #(
        .BUCKETS (BUCKETS),
        .NODES   (NODES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .func      (func),
        .key       (key),
        .hash_in   (hash_in),
        .value_in  (value_in),
        .status    (status),
        .value_out (value_out)
    );

endmodule

`default_nettype wire

// ===== sv/chash_dp.sv =====
// Datapath: request registers, bucket remainder unit, chain memories and result register.
`default_nettype none

module chash_dp #(
    parameter int BUCKETS = 16,
    parameter int NODES   = 256
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  chash_pkg::cmd_t     cmd,
    output chash_pkg::sts_t     sts,
    input  wire                 func,
    input  wire  [31:0]         key,
    input  wire  [31:0]         hash_in,
    input  wire  [31:0]         value_in,
    output logic [1:0]          status,
    output logic [31:0]         value_out
);
    import chash_pkg::*;

    localparam int BW = $clog2(BUCKETS);
    localparam int NW = $clog2(NODES);
    localparam int CW = $clog2(NODES + 1);
    localparam bit POW2 = (BUCKETS & (BUCKETS - 1)) == 0;
    localparam logic [BW-1:0] LAST_BUCKET = BW'(BUCKETS - 1);
    localparam logic [CW-1:0] NODES_C = CW'(NODES);

    logic          func_reg;
    logic [31:0]   key_reg;
    logic [31:0]   hash_reg;
    logic [31:0]   val_reg;

    logic [BW-1:0] bucket;
    logic          mod_done;

    logic [NW:0]   head_mem [BUCKETS];
    logic [NW:0]   head_q_reg;
    logic [BW-1:0] clr_cnt_reg;
    logic          clear_done_reg;

    logic [31:0]   key_mem  [NODES];
    logic [31:0]   hash_mem [NODES];
    logic [31:0]   val_mem  [NODES];
    logic [NW:0]   link_mem [NODES];
    logic [31:0]   key_q_reg;
    logic [31:0]   hash_q_reg;
    logic [31:0]   val_q_reg;
    logic [NW:0]   link_q_reg;
    logic [NW-1:0] cur_reg;
    logic          have_last_reg;
    logic [CW-1:0] count_reg;

    logic [NW-1:0] rd_addr;
    logic [NW-1:0] new_idx;
    logic          head_we;
    logic [BW-1:0] head_addr;
    logic [NW:0]   head_wdata;
    logic          val_we;
    logic [NW-1:0] val_addr;
    logic          link_we;
    logic [NW-1:0] link_addr;
    logic [NW:0]   link_wdata;

    logic [1:0]    status_reg;
    logic [31:0]   value_out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            func_reg <= func;
            key_reg  <= key;
            hash_reg <= hash_in;
            val_reg  <= value_in;
        end
    end

    generate
        if (POW2)
        begin : g_mask
            assign bucket   = hash_reg[BW-1:0];
            assign mod_done = 1'b1;
        end
        else
        begin : g_recip
            localparam int            QSH      = 32 + BW;
            localparam logic [32:0]   RECIP    =
                33'(((64'd1 << QSH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));
            localparam logic [15:0]   RECIP_LO = RECIP[15:0];
            localparam logic [16:0]   RECIP_HI = RECIP[32:16];
            localparam logic [BW-1:0] DIV_LOW  = BW'(BUCKETS);
            logic [47:0]     prod_lo_reg;
            logic [48:0]     prod_hi_reg;
            logic [BW-1:0]   quot_reg;
            logic [BW-1:0]   rem_reg;
            logic [1:0]      step_reg;
            logic [64:0]     prod_sum;
            logic [2*BW-1:0] quot_mul;
            logic [BW-1:0]   rem_next;

            always_comb
            begin
                prod_sum = 65'(prod_lo_reg) + {prod_hi_reg, 16'd0};
                quot_mul = {{BW{1'b0}}, quot_reg} * {{BW{1'b0}}, DIV_LOW};
                rem_next = hash_reg[BW-1:0] - quot_mul[BW-1:0];
            end

            always_ff @(posedge clk)
            begin
                if (cmd.load_req)
                    step_reg <= 2'd0;
                else if (cmd.mod_step)
                begin
                    step_reg <= step_reg + 2'd1;
                    if (step_reg == 2'd0)
                    begin
                        prod_lo_reg <= 48'(hash_reg) * 48'(RECIP_LO);
                        prod_hi_reg <= 49'(hash_reg) * 49'(RECIP_HI);
                    end
                    if (step_reg == 2'd1)
                        quot_reg <= prod_sum[QSH +: BW];
                    if (step_reg == 2'd2)
                        rem_reg <= rem_next;
                end
            end

            assign bucket   = rem_reg;
            assign mod_done = step_reg == 2'd3;
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg    <= '0;
            clear_done_reg <= 1'b0;
            count_reg      <= '0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                if (clr_cnt_reg == LAST_BUCKET)
                    clear_done_reg <= 1'b1;
                else
                    clr_cnt_reg <= clr_cnt_reg + BW'(1);
            end
            if (cmd.ins_node)
                count_reg <= count_reg + CW'(1);
        end
    end

    assign new_idx    = count_reg[NW-1:0];
    assign head_we    = cmd.clear_step | (cmd.ins_node & ~have_last_reg);
    assign head_addr  = cmd.clear_step ? clr_cnt_reg : bucket;
    assign head_wdata = cmd.clear_step ? '0 : {1'b1, new_idx};

    always_ff @(posedge clk)
    begin
        if (head_we)
            head_mem[head_addr] <= head_wdata;
        if (cmd.head_rd)
            head_q_reg <= head_mem[bucket];
    end

    assign rd_addr    = cmd.node_rd_head ? head_q_reg[NW-1:0] : link_q_reg[NW-1:0];
    assign val_we     = cmd.write_value | cmd.ins_node;
    assign val_addr   = cmd.ins_node ? new_idx : cur_reg;
    assign link_we    = cmd.ins_link | cmd.ins_node;
    assign link_addr  = cmd.ins_node ? new_idx : cur_reg;
    assign link_wdata = cmd.ins_node ? '0 : {1'b1, new_idx};

    always_ff @(posedge clk)
    begin
        if (cmd.ins_node)
        begin
            key_mem[new_idx]  <= key_reg;
            hash_mem[new_idx] <= hash_reg;
        end
        if (val_we)
            val_mem[val_addr] <= val_reg;
        if (link_we)
            link_mem[link_addr] <= link_wdata;
        if (cmd.node_rd_head | cmd.node_rd_link)
        begin
            key_q_reg  <= key_mem[rd_addr];
            hash_q_reg <= hash_mem[rd_addr];
            val_q_reg  <= val_mem[rd_addr];
            link_q_reg <= link_mem[rd_addr];
            cur_reg    <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            have_last_reg <= 1'b0;
        else if (cmd.load_req)
            have_last_reg <= 1'b0;
        else if (cmd.node_rd_head)
            have_last_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            status_reg    <= cmd.res_status;
            value_out_reg <= cmd.res_hit_value ? val_q_reg : 32'd0;
        end
    end

    assign sts.clear_done = clear_done_reg;
    assign sts.mod_done   = mod_done;
    assign sts.head_valid = head_q_reg[NW];
    assign sts.node_match = (hash_q_reg == hash_reg) && (key_q_reg == key_reg);
    assign sts.link_valid = link_q_reg[NW];
    assign sts.have_last  = have_last_reg;
    assign sts.full       = count_reg == NODES_C;
    assign sts.func       = func_reg;

    assign status    = status_reg;
    assign value_out = value_out_reg;

endmodule

`default_nettype wire

// ===== sv/chash_ctrl.sv =====
// Controller: sequences bucket clear, chain walk, update and result handoff.
`default_nettype none

module chash_ctrl (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  wire              out_ready,
    output chash_pkg::cmd_t  cmd,
    input  chash_pkg::sts_t  sts
);
    import chash_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_HEAD,
        S_HEADCHK,
        S_WALK,
        S_HIT,
        S_MISS,
        S_LINK,
        S_NODE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = ~out_valid_reg | out_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (sts.clear_done)
                    state_next = S_IDLE;
                else
                    cmd.clear_step = 1'b1;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_MOD;
                end
            end
            S_MOD:
            begin
                if (sts.mod_done)
                    state_next = S_HEAD;
                else
                    cmd.mod_step = 1'b1;
            end
            S_HEAD:
            begin
                cmd.head_rd = 1'b1;
                state_next  = S_HEADCHK;
            end
            S_HEADCHK:
            begin
                if (sts.head_valid)
                begin
                    cmd.node_rd_head = 1'b1;
                    state_next       = S_WALK;
                end
                else
                    state_next = S_MISS;
            end
            S_WALK:
            begin
                if (sts.node_match)
                    state_next = S_HIT;
                else if (sts.link_valid)
                    cmd.node_rd_link = 1'b1;
                else
                    state_next = S_MISS;
            end
            S_HIT:
            begin
                if (out_free)
                begin
                    cmd.res_load      = 1'b1;
                    cmd.res_status    = STATUS_HIT;
                    cmd.res_hit_value = (sts.func == FUNC_LOOKUP);
                    cmd.write_value   = (sts.func == FUNC_INSERT);
                    state_next        = S_IDLE;
                end
            end
            S_MISS:
            begin
                if (sts.func == FUNC_INSERT && !sts.full)
                    state_next = sts.have_last ? S_LINK : S_NODE;
                else if (out_free)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = (sts.func == FUNC_LOOKUP) ? STATUS_NEW : STATUS_FULL;
                    state_next     = S_IDLE;
                end
            end
            S_LINK:
            begin
                cmd.ins_link = 1'b1;
                state_next   = S_NODE;
            end
            S_NODE:
            begin
                if (out_free)
                begin
                    cmd.ins_node   = 1'b1;
                    cmd.res_load   = 1'b1;
                    cmd.res_status = STATUS_NEW;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.res_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== verif/chash_checker.sv =====
// Checker for the chained hash table: predicts each reply and compares it with the block's.
module chash_checker #(
    parameter int BUCKETS = 16,
    parameter int NODES   = 256
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    input  wire         in_ready,
    input  wire         func,
    input  wire  [31:0] key,
    input  wire  [31:0] hash_in,
    input  wire  [31:0] value_in,
    input  wire         out_valid,
    input  wire         out_ready,
    input  wire  [1:0]  status,
    input  wire  [31:0] value_out,
    output int          fail_count,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import chash_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value;
    } reply_t;

    logic [8:0]  chain_head [BUCKETS];
    logic        chain_live [BUCKETS];
    logic [31:0] entry_key  [NODES];
    logic [31:0] entry_hash [NODES];
    logic [31:0] entry_value[NODES];
    logic [8:0]  entry_next [NODES];
    logic        entry_more [NODES];
    int unsigned nodes_taken;

    reply_t predicted_replies[$];
    int     mismatches;

    function automatic reply_t apply_request(logic op, logic [31:0] k, logic [31:0] h,
                                             logic [31:0] v);
        int unsigned bucket;
        logic        walking;
        int unsigned at;
        logic        has_tail;
        int unsigned tail;
        logic        hit;
        int unsigned visited;
        reply_t      r;
        bucket   = h % BUCKETS;
        walking  = chain_live[bucket];
        at       = chain_head[bucket];
        has_tail = 1'b0;
        tail     = 0;
        hit      = 1'b0;
        visited  = 0;
        r.value  = '0;
        while (walking && visited < nodes_taken && at < NODES) begin
            if (entry_hash[at] == h && entry_key[at] == k) begin
                hit = 1'b1;
                break;
            end
            has_tail = 1'b1;
            tail     = at;
            walking  = entry_more[at];
            at       = entry_next[at];
            visited++;
        end
        if (op == FUNC_LOOKUP) begin
            if (hit) begin
                r.status = STATUS_HIT;
                r.value  = entry_value[at];
            end
            else
                r.status = STATUS_NEW;
        end
        else if (hit) begin
            entry_value[at] = v;
            r.status = STATUS_HIT;
        end
        else if (nodes_taken >= NODES)
            r.status = STATUS_FULL;
        else begin
            entry_key[nodes_taken]   = k;
            entry_hash[nodes_taken]  = h;
            entry_value[nodes_taken] = v;
            entry_next[nodes_taken]  = '0;
            entry_more[nodes_taken]  = 1'b0;
            if (has_tail) begin
                entry_more[tail] = 1'b1;
                entry_next[tail] = 9'(nodes_taken);
            end
            else begin
                chain_live[bucket] = 1'b1;
                chain_head[bucket] = 9'(nodes_taken);
            end
            nodes_taken++;
            r.status = STATUS_NEW;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        if (!rst_n)
        begin
            for (int b = 0; b < BUCKETS; b++)
            begin
                chain_head[b] = '0;
                chain_live[b] = 1'b0;
            end
            nodes_taken = 0;
            mismatches  = 0;
            predicted_replies.delete();
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (predicted_replies.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected reply: status %0d value %h", status, value_out);
                    mismatches++;
                end
                else
                begin
                    want = predicted_replies.pop_front();
                    if (status !== want.status || value_out !== want.value)
                    begin
                        if (mismatches < 10)
                            $display("reply mismatch: status exp %0d got %0d, value exp %h got %h",
                                     want.status, status, want.value, value_out);
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
                predicted_replies.push_back(apply_request(func, key, hash_in, value_in));
            fail_count  <= mismatches;
            outstanding <= predicted_replies.size();
        end
    end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for the chained hash table: clock, reset, request stimulus and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import chash_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        func;
    logic [31:0] key;
    logic [31:0] hash_in;
    logic [31:0] value_in;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [31:0] value_out;
    int          fail_count;
    int          outstanding;
    logic        steady;

    logic [31:0] known_keys[$];
    logic [31:0] known_hashes[$];

    chained_hash_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .key       (key),
        .hash_in   (hash_in),
        .value_in  (value_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .value_out (value_out)
    );

    chash_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .key         (key),
        .hash_in     (hash_in),
        .value_in    (value_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .value_out   (value_out),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic send_request(input logic op, input logic [31:0] k, input logic [31:0] h,
                                input logic [31:0] v);
        if (!steady && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= op;
        key      <= k;
        hash_in  <= h;
        value_in <= v;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (op == FUNC_INSERT)
        begin
            known_keys.push_back(k);
            known_hashes.push_back(h);
        end
    endtask

    task automatic send_random_request();
        int unsigned pick;
        int unsigned idx;
        logic [31:0] k;
        logic [31:0] h;
        logic [31:0] noise;
        pick  = $urandom_range(0, 99);
        k     = $urandom;
        h     = $urandom;
        noise = $urandom;
        if (known_keys.size() > 0 && pick < 72)
        begin
            idx = $urandom_range(0, known_keys.size() - 1);
            if (pick < 55)
            begin
                k = known_keys[idx];
                h = known_hashes[idx];
            end
            else if (pick < 65)
            begin
                k = known_keys[idx];
                h = {noise[31:4], known_hashes[idx][3:0]};
            end
            else
                h = known_hashes[idx];
        end
        send_request($urandom_range(0, 1) ? FUNC_INSERT : FUNC_LOOKUP, k, h, $urandom);
    endtask

    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!steady && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    initial
    begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        func     <= FUNC_LOOKUP;
        key      <= '0;
        hash_in  <= '0;
        value_in <= '0;
        steady   <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(FUNC_INSERT, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_request(FUNC_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(FUNC_INSERT, 32'h0000_0000, 32'h0000_0000, 32'h1234_5678);
        send_request(FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_request(FUNC_INSERT, 32'h0000_0001, 32'h0000_0010, 32'hA5A5_A5A5);
        send_request(FUNC_INSERT, 32'h0000_0001, 32'h0000_0000, 32'h5A5A_5A5A);
        send_request(FUNC_LOOKUP, 32'h0000_0001, 32'h0000_0010, 32'h0000_0000);
        send_request(FUNC_LOOKUP, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000);
        send_request(FUNC_LOOKUP, 32'h0000_0002, 32'h0000_0000, 32'h0000_0000);
        send_request(FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0020, 32'h0000_0000);
        send_request(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(FUNC_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000);
        send_request(FUNC_INSERT, 32'h0000_0001, 32'h0000_0010, 32'h0000_0000);
        send_request(FUNC_LOOKUP, 32'h0000_0001, 32'h0000_0010, 32'hFFFF_FFFF);

        repeat (1400) send_random_request();
        steady = 1'b1;
        repeat (200) send_random_request();
        in_valid <= 1'b0;
        @(posedge clk);

        while (outstanding != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #30_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
